// ===== rtl/tsedl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tsedl_pkg;

    localparam int DEPTH     = 131072;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int LEN_W     = ADDR_W + 1;
    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 12;
    localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;
    localparam int OUT_W     = 21;
    localparam int CFG_W     = 18;
    localparam int IDX_W     = 2;

    localparam logic [CFG_W-1:0]  RST_FIRST_LENGTH  = CFG_W'(131072);
    localparam logic [CFG_W-1:0]  RST_SECOND_LENGTH = CFG_W'(131072);
    localparam logic [GAIN_W-1:0] RST_FIRST_GAIN    = GAIN_W'(2048);
    localparam logic [GAIN_W-1:0] RST_SECOND_GAIN   = GAIN_W'(819);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [GAIN_W-1:0]          t_gain;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [OUT_W-1:0]    t_out;

    localparam t_out Q_ONE = OUT_W'(2 ** (SAMPLE_W - 1));

    typedef enum logic [IDX_W-1:0] {
        REG_FIRST_LENGTH  = 2'd0,
        REG_SECOND_LENGTH = 2'd1,
        REG_FIRST_GAIN    = 2'd2,
        REG_SECOND_GAIN   = 2'd3
    } t_reg_idx;

endpackage

`default_nettype wire

// ===== rtl/tsedl_ring.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tsedl_ring
    import tsedl_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_clr,
    input  wire logic             i_en,
    input  wire logic [LEN_W-1:0] i_len,
    input  wire t_sample          i_data,
    output t_sample               o_data
);

    logic [LEN_W-1:0]  len_eff;
    logic              byp;
    logic [LEN_W-1:0]  wnext;
    logic [LEN_W-1:0]  rnext;
    logic [ADDR_W-1:0] r_wpos, n_wpos;
    logic [ADDR_W-1:0] r_rpos, n_rpos;
    logic [LEN_W-1:0]  r_fill, n_fill;
    logic              r_byp;
    logic              r_hit;
    t_sample           r_mem [DEPTH];
    t_sample           r_rd;
    t_sample           r_hold;

    always_comb begin
        len_eff = (i_len > LEN_W'(DEPTH)) ? LEN_W'(DEPTH) : i_len;
        byp     = (len_eff <= LEN_W'(1));
        wnext   = {1'b0, r_wpos} + LEN_W'(1);
        rnext   = {1'b0, r_rpos} + LEN_W'(1);
        n_wpos  = (wnext >= len_eff) ? '0 : wnext[ADDR_W-1:0];
        n_rpos  = (rnext >= len_eff) ? '0 : rnext[ADDR_W-1:0];
        // written entries always form a prefix from zero
        n_fill  = (wnext > r_fill) ? wnext : r_fill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos <= '0;
            r_rpos <= ADDR_W'(1);
            r_fill <= '0;
            r_byp  <= 1'b0;
            r_hit  <= 1'b0;
        end else if (i_clr) begin
            r_wpos <= '0;
            r_rpos <= ADDR_W'(1);
        end else if (i_en) begin
            r_byp <= byp;
            r_hit <= ({1'b0, r_rpos} < r_fill);
            if (!byp) begin
                r_wpos <= n_wpos;
                r_rpos <= n_rpos;
                r_fill <= n_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hold <= i_data;
            if (!byp) begin
                r_mem[r_wpos] <= i_data;
                r_rd          <= r_mem[r_rpos];
            end
        end
    end

    assign o_data = r_byp ? r_hold : (r_hit ? r_rd : '0);

endmodule

`default_nettype wire

// ===== rtl/two_stage_echo_delay_line_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// path: ring 1 read register; r_tap1 and ring 2 read register; products; r_echo
// throughput: one sample per cycle unless the output stalls; each ring not passing
// straight through does one read and one write of its dual-port memory per sample
// reset: synchronous, clears positions, fill marks and pipeline valids; no clearing
// pass, entries never written since reset read as zero, ready the cycle after reset

module two_stage_echo_delay_line_top
    import tsedl_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_sample          i_sample_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out                  o_echo_out,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    logic [LEN_W-1:0] r_len1, r_len2;
    t_gain            r_gain1, r_gain2;
    logic             cfg_fire;
    logic             clr;
    t_reg_idx         cfg_idx;

    logic             r_v1, r_v2, r_v3, r_out_valid;
    logic             rdy1, rdy2, rdy3, rdy_o;
    logic             fire0, ld2, ld3, ld_o;
    t_sample          tap1, tap2;
    t_sample          r_tap1;
    t_prod            r_p1, r_p2;
    t_out             q1, q2;
    t_out             r_echo;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid & o_cfg_ready;
    assign cfg_idx     = t_reg_idx'(i_cfg_index);
    assign clr         = cfg_fire &&
                         (cfg_idx == REG_FIRST_LENGTH || cfg_idx == REG_SECOND_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len1  <= LEN_W'(RST_FIRST_LENGTH);
            r_len2  <= LEN_W'(RST_SECOND_LENGTH);
            r_gain1 <= RST_FIRST_GAIN;
            r_gain2 <= RST_SECOND_GAIN;
        end else if (cfg_fire) begin
            unique case (cfg_idx)
                REG_FIRST_LENGTH:  r_len1  <= LEN_W'(i_cfg_data);
                REG_SECOND_LENGTH: r_len2  <= LEN_W'(i_cfg_data);
                REG_FIRST_GAIN:    r_gain1 <= i_cfg_data[GAIN_W-1:0];
                REG_SECOND_GAIN:   r_gain2 <= i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // per-stage handshake
    assign rdy_o = !r_out_valid | i_out_ready;
    assign rdy3  = !r_v3 | rdy_o;
    assign rdy2  = !r_v2 | rdy3;
    assign rdy1  = !r_v1 | rdy2;
    assign fire0 = i_in_valid & rdy1;
    assign ld2   = r_v1 & rdy2;
    assign ld3   = r_v2 & rdy3;
    assign ld_o  = r_v3 & rdy_o;

    assign o_in_ready = rdy1;

    tsedl_ring u_ring1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (clr),
        .i_en    (fire0),
        .i_len   (r_len1),
        .i_data  (i_sample_in),
        .o_data  (tap1)
    );

    tsedl_ring u_ring2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (clr),
        .i_en    (ld2),
        .i_len   (r_len2),
        .i_data  (tap1),
        .o_data  (tap2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_in_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy_o) r_out_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld2) r_tap1 <= tap1;
        if (ld3) begin
            r_p1 <= PROD_W'(r_tap1) * PROD_W'($signed({1'b0, r_gain1}));
            r_p2 <= PROD_W'(tap2) * PROD_W'($signed({1'b0, r_gain2}));
        end
        if (ld_o) r_echo <= q1 + q2;
    end

    // floor shift to q.15, upper clamp at one
    always_comb begin
        q1 = OUT_W'(r_p1 >>> GAIN_FRAC);
        q2 = OUT_W'(r_p2 >>> GAIN_FRAC);
        if (q1 > Q_ONE) q1 = Q_ONE;
        if (q2 > Q_ONE) q2 = Q_ONE;
    end

    assign o_out_valid = r_out_valid;
    assign o_echo_out  = r_echo;

endmodule

`default_nettype wire

// ===== rtl/tsedl_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tsedl_checker
    import tsedl_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_ready,
    input wire logic             o_out_valid,
    input wire logic             i_out_ready,
    input wire t_out             o_echo_out,
    input wire logic             o_cfg_ready
);

    logic in_fire;

    assign in_fire = i_in_valid & o_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_echo_out))
        else $error("stalled output transaction changed");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready && !o_out_valid)
        else $error("not ready or output valid after reset");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready |=> o_out_valid)
        else $error("accepted sample did not reach output in four cycles");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind two_stage_echo_delay_line_top tsedl_checker u_tsedl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_echo_out  (o_echo_out),
    .o_cfg_ready (o_cfg_ready)
);

`default_nettype wire

// ===== tb/echo_delay_checker.sv =====
`timescale 1ns / 1ps

module echo_delay_checker
    import tsedl_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_ready,
    input  wire t_sample          i_sample_in,
    input  wire logic             i_out_valid,
    input  wire logic             i_out_ready,
    input  wire t_out             i_echo_out,
    input  wire logic             i_cfg_valid,
    input  wire logic             i_cfg_ready,
    input  wire logic [IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    t_sample          ring_mem [2][DEPTH];
    int unsigned      wr_pos [2];
    int unsigned      rd_pos [2];
    logic [CFG_W-1:0] ring_len [2];
    t_gain            tap_gain [2];
    t_out             echo_fifo [$];
    int               mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    task automatic report_mismatch(input string what);
        if (mismatch_count < 100) begin
            $display("mismatch at %0t ns: %s", $time, what);
        end
        mismatch_count++;
    endtask

    function automatic void home_positions();
        wr_pos[0] = 0;
        rd_pos[0] = 1;
        wr_pos[1] = 0;
        rd_pos[1] = 1;
    endfunction

    // lengths of 0 or 1 pass straight through, above the store size act as full size
    function automatic t_sample ring_step(input int k, input t_sample v);
        int unsigned len;
        t_sample     r;
        len = (ring_len[k] > DEPTH) ? DEPTH : ring_len[k];
        if (len <= 1) return v;
        if (wr_pos[k] >= len) wr_pos[k] = 0;
        if (rd_pos[k] >= len) rd_pos[k] = 0;
        ring_mem[k][wr_pos[k]] = v;
        r = ring_mem[k][rd_pos[k]];
        wr_pos[k] = (wr_pos[k] + 1 >= len) ? 0 : wr_pos[k] + 1;
        rd_pos[k] = (rd_pos[k] + 1 >= len) ? 0 : rd_pos[k] + 1;
        return r;
    endfunction

    // floor shift to q.15, upper clamp only
    function automatic t_out scale_tap(input t_sample tap, input t_gain g);
        t_prod prod;
        t_prod q;
        prod = t_prod'(tap) * t_prod'({1'b0, g});
        q = prod >>> GAIN_FRAC;
        if (q > t_prod'(Q_ONE)) q = t_prod'(Q_ONE);
        return t_out'(q);
    endfunction

    function automatic t_out predict_echo(input t_sample s);
        t_sample tap1;
        t_sample tap2;
        tap1 = ring_step(0, s);
        tap2 = ring_step(1, tap1);
        return scale_tap(tap1, tap_gain[0]) + scale_tap(tap2, tap_gain[1]);
    endfunction

    always @(posedge i_clk) begin
        t_out expected;
        if (!i_rst_n) begin
            for (int j = 0; j < DEPTH; j++) begin
                ring_mem[0][j] = '0;
                ring_mem[1][j] = '0;
            end
            home_positions();
            ring_len[0] = RST_FIRST_LENGTH;
            ring_len[1] = RST_SECOND_LENGTH;
            tap_gain[0] = RST_FIRST_GAIN;
            tap_gain[1] = RST_SECOND_GAIN;
            echo_fifo.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_FIRST_LENGTH: begin
                        ring_len[0] = i_cfg_data;
                        home_positions();
                    end
                    REG_SECOND_LENGTH: begin
                        ring_len[1] = i_cfg_data;
                        home_positions();
                    end
                    REG_FIRST_GAIN:  tap_gain[0] = t_gain'(i_cfg_data);
                    REG_SECOND_GAIN: tap_gain[1] = t_gain'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (echo_fifo.size() == 0) begin
                    report_mismatch($sformatf("echo %0d with no transaction pending", i_echo_out));
                end else begin
                    expected = echo_fifo.pop_front();
                    if (i_echo_out !== expected) begin
                        report_mismatch($sformatf("echo_out got %0d expected %0d",
                                                  i_echo_out, expected));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                echo_fifo.push_back(predict_echo(i_sample_in));
            end
        end
        o_pending = echo_fifo.size();
    end

endmodule

// ===== tb/tb_two_stage_echo_delay_line_top.sv =====
`timescale 1ns / 1ps

module tb_two_stage_echo_delay_line_top;
    import tsedl_pkg::*;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    t_sample          sample_in;
    logic             out_valid;
    logic             out_ready;
    t_out             echo_out;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    int               fail_count;
    int               pending;
    bit               tx_idle_on;
    bit               rx_idle_on;
    int               hold_left = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    two_stage_echo_delay_line_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_sample_in (sample_in),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_echo_out  (echo_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    echo_delay_checker u_echo_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_sample_in  (sample_in),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_echo_out   (echo_out),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    task automatic offer_sample(input t_sample s);
        while (tx_idle_on && $urandom_range(99) < 26) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_echoes();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic set_gains(input t_gain g1, input t_gain g2);
        drain_echoes();
        write_reg(REG_FIRST_GAIN, CFG_W'(g1));
        write_reg(REG_SECOND_GAIN, CFG_W'(g2));
        cfg_valid <= 1'b0;
    endtask

    task automatic set_rings(input logic [CFG_W-1:0] len1, input logic [CFG_W-1:0] len2,
                             input t_gain g1, input t_gain g2);
        drain_echoes();
        write_reg(REG_FIRST_LENGTH, len1);
        write_reg(REG_SECOND_LENGTH, len2);
        write_reg(REG_FIRST_GAIN, CFG_W'(g1));
        write_reg(REG_SECOND_GAIN, CFG_W'(g2));
        cfg_valid <= 1'b0;
    endtask

    function automatic t_sample pick_sample();
        if ($urandom_range(99) < 12) begin
            case ($urandom_range(3))
                0: return 16'sh7FFF;
                1: return 16'sh8000;
                2: return 16'sh0000;
                default: return 16'shFFFF;
            endcase
        end
        return t_sample'($urandom);
    endfunction

    function automatic logic [CFG_W-1:0] pick_length();
        case ($urandom_range(9))
            0: return CFG_W'(0);
            1: return CFG_W'(1);
            2: return CFG_W'(2);
            3, 4: return CFG_W'($urandom_range(3, 16));
            5, 6: return CFG_W'($urandom_range(17, 400));
            7: return CFG_W'(DEPTH);
            8: return CFG_W'($urandom_range(DEPTH + 1, 2 ** CFG_W - 1));
            default: return CFG_W'($urandom_range(401, DEPTH - 1));
        endcase
    endfunction

    function automatic t_gain pick_gain();
        case ($urandom_range(5))
            0: return t_gain'(0);
            1: return t_gain'(16'hFFFF);
            2: return t_gain'(4096);
            default: return t_gain'($urandom_range(0, 65535));
        endcase
    endfunction

    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= !(rx_idle_on && $urandom_range(99) < 26);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("FAIL two_stage_echo_delay_line_top");
        $finish;
    end

    initial begin
        t_gain g1;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        sample_in  = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings, long rings read back zeros
        offer_sample(16'sh7FFF);
        offer_sample(16'sh8000);
        offer_sample(16'sh0000);
        offer_sample(16'shFFFF);

        // both rings pass straight through, full gain hits the upper clamp
        set_rings(CFG_W'(0), CFG_W'(1), t_gain'(16'hFFFF), t_gain'(16'hFFFF));
        offer_sample(16'sh7FFF);
        offer_sample(16'sh8000);
        offer_sample(16'sh0001);
        offer_sample(16'shFFFF);
        offer_sample(16'sh5555);
        offer_sample(16'shAAAA);

        // shortest real delays, negative taps floor
        set_rings(CFG_W'(2), CFG_W'(3), t_gain'(4096), t_gain'(2048));
        offer_sample(16'sh7FFF);
        offer_sample(16'sh8000);
        offer_sample(16'shFFFF);
        offer_sample(16'sh0001);
        offer_sample(16'sh0064);
        offer_sample(16'shFF9C);
        offer_sample(16'sh0007);

        // oversized length behaves as full size
        set_rings(CFG_W'(2 ** CFG_W - 1), CFG_W'(DEPTH), t_gain'(0), t_gain'(16'hFFFF));
        offer_sample(16'sh1234);
        offer_sample(16'sh8000);
        offer_sample(16'sh7FFF);

        // length write alone sends positions home, stores keep contents
        drain_echoes();
        write_reg(REG_FIRST_LENGTH, CFG_W'(2));
        cfg_valid <= 1'b0;
        offer_sample(16'sh4000);
        offer_sample(16'shC000);
        offer_sample(16'sh0100);

        for (int ph = 0; ph < 12; ph++) begin
            tx_idle_on = (ph != 2 && ph != 3);
            rx_idle_on = tx_idle_on;
            g1 = pick_gain();
            if (ph == 5) begin
                set_rings(pick_length(), pick_length(), g1, t_gain'((g1 * 2) / 5));
            end else if (ph < 2 || $urandom_range(2) != 0) begin
                set_rings(pick_length(), pick_length(), g1, pick_gain());
            end else begin
                set_gains(g1, pick_gain());
            end
            for (int n = 0; n < 160; n++) begin
                if ((ph == 4 || ph == 9) && n == 40) hold_left = 300;
                offer_sample(pick_sample());
            end
        end

        drain_echoes();
        repeat (12) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS two_stage_echo_delay_line_top");
        end else begin
            $display("FAIL two_stage_echo_delay_line_top");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tsedl_pkg.sv
rtl/tsedl_ring.sv
rtl/two_stage_echo_delay_line_top.sv
rtl/tsedl_checker.sv
tb/echo_delay_checker.sv
tb/tb_two_stage_echo_delay_line_top.sv
